// ===== design/rmrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmrc_pkg
// Shared types, codes and constants of the ROMM mesh route computation block.
// ----------------------------------------------------------------------------
package rmrc_pkg;

  // Default geometry and retry budget
  localparam int COORD_BITS_DEF  = 4;
  localparam int MAX_TRIES_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Random generator
  localparam int              SEED_W     = 16;
  localparam logic [SEED_W-1:0] SEED_RESET = 16'd44257;
  localparam logic [SEED_W-1:0] LFSR_TAPS  = 16'hB400;

  // Configuration register indexes
  localparam int              CFG_IDX_W    = 2;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED   = 2'd2;

  // How the back end has to treat a queued header
  typedef enum logic [1:0] {
    OP_TRANSIT = 2'd0,  // from a neighbor, via node already settled
    OP_DIRECT  = 2'd1,  // injected, no third node: head for the target
    OP_DRAW    = 2'd2   // injected, draw a random intermediate node
  } op_e;

  // Output ports of the router
  typedef enum logic [2:0] {
    PORT_LOCAL = 3'd0,
    PORT_NORTH = 3'd1,
    PORT_EAST  = 3'd2,
    PORT_SOUTH = 3'd3,
    PORT_WEST  = 3'd4
  } port_e;

  // Back end sequencer
  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_DRAW_X = 3'd1,
    ST_DRAW_Y = 3'd2,
    ST_CHECK  = 3'd3,
    ST_ROUTE  = 3'd4
  } state_e;

  // One Galois LFSR step
  function automatic logic [SEED_W-1:0] lfsr_next(input logic [SEED_W-1:0] s);
    lfsr_next = (s >> 1) ^ (s[0] ? LFSR_TAPS : '0);
  endfunction

endpackage

// ===== design/romm_mesh_route_compute.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// romm_mesh_route_compute
// Two-phase randomized minimal (ROMM) route computation for one mesh router.
// ----------------------------------------------------------------------------
// Each header transaction yields exactly one result transaction, in order.
// A header from a neighbor, or an injected header whose rectangle to the
// target holds no third node, is loaded and then routed in the back end.
// An injected header that needs a random intermediate node is loaded, makes
// 1 to MAX_TRIES draw attempts and is then routed; each attempt draws
// one coordinate after the other on the single LFSR-times-span multiplier
// and then runs the reject check. A two-entry queue sits between the
// classifying front end and the back end, so headers keep being accepted
// while a draw is in progress, and the output register lets the back end
// load and draw the next header while a result waits to be taken.
// Configuration: write node_x (index 0), node_y (index 1) or random_seed
// (index 2) only while the block is idle; a seed write reloads the
// generator at once, and a zero seed loads the reset seed instead.
// ----------------------------------------------------------------------------
module romm_mesh_route_compute #(
  parameter int COORD_BITS  = rmrc_pkg::COORD_BITS_DEF,
  parameter int MAX_TRIES   = rmrc_pkg::MAX_TRIES_DEF,
  parameter int QUEUE_DEPTH = rmrc_pkg::QUEUE_DEPTH_DEF,
  // derived widths
  parameter int IN_W  = ((4 * COORD_BITS + 1 + 7) / 8) * 8,
  parameter int OUT_W = ((2 * COORD_BITS + 4 + 7) / 8) * 8,
  parameter int CFG_W = (COORD_BITS > rmrc_pkg::SEED_W) ? COORD_BITS : rmrc_pkg::SEED_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [rmrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i,
  // header input
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // tdata: target_x, target_y, via_x, via_y, via_reached, zero pad
  input  logic [IN_W-1:0]                s_axis_tdata_i,
  // tuser: kind (0 injected locally, 1 from a neighbor)
  input  logic                           s_axis_tuser_i,
  // route result output
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // tdata: out_port, new_via_x, new_via_y, new_via_reached, zero pad
  output logic [OUT_W-1:0]               m_axis_tdata_o
);
  import rmrc_pkg::*;

  // queue entry: op, reached, base x/y, span x/y, via x/y, target x/y
  localparam int EntryW = 8 * COORD_BITS + 5;

  logic                  fq_valid, fq_ready;
  logic [EntryW-1:0]     fq_data;
  logic                  qb_valid, qb_ready;
  logic [EntryW-1:0]     qb_data;
  logic [COORD_BITS-1:0] node_x, node_y;
  logic                  seed_we;

  assign seed_we = cfg_we_i && (cfg_idx_i == REG_SEED);

  // Front end: accept headers, hold node coordinates, classify
  rmrc_front #(
    .COORD_BITS (COORD_BITS),
    .IN_W       (IN_W),
    .ENTRY_W    (EntryW),
    .CFG_W      (CFG_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .q_valid_o       (fq_valid),
    .q_ready_i       (fq_ready),
    .q_data_o        (fq_data),
    .node_x_o        (node_x),
    .node_y_o        (node_y)
  );

  // Decoupling queue
  rmrc_queue #(
    .WIDTH (EntryW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  // Back end: draw the via node, route, drive the result
  rmrc_back #(
    .COORD_BITS (COORD_BITS),
    .MAX_TRIES  (MAX_TRIES),
    .ENTRY_W    (EntryW),
    .OUT_W      (OUT_W)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seed_we_i       (seed_we),
    .seed_i          (cfg_wdata_i[SEED_W-1:0]),
    .node_x_i        (node_x),
    .node_y_i        (node_y),
    .q_valid_i       (qb_valid),
    .q_ready_o       (qb_ready),
    .q_data_i        (qb_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== design/rmrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmrc_front
// Accept header transactions, hold the node coordinates and classify each
// header into a queue entry for the back end.
// ----------------------------------------------------------------------------
module rmrc_front #(
  parameter int COORD_BITS = rmrc_pkg::COORD_BITS_DEF,
  parameter int IN_W       = 24,
  parameter int ENTRY_W    = 8 * COORD_BITS + 5,
  parameter int CFG_W      = rmrc_pkg::SEED_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rmrc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]               cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [IN_W-1:0]                s_axis_tdata_i,
  input  logic                           s_axis_tuser_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output logic [ENTRY_W-1:0]             q_data_o,
  output logic [COORD_BITS-1:0]          node_x_o,
  output logic [COORD_BITS-1:0]          node_y_o
);
  import rmrc_pkg::*;

  localparam int SpanW = COORD_BITS + 1;

  logic [COORD_BITS-1:0] node_x_q, node_x_d;
  logic [COORD_BITS-1:0] node_y_q, node_y_d;

  logic [COORD_BITS-1:0] tx, ty, vx, vy, bx, by, ex, ey;
  logic                  reached_in, reached;
  logic [SpanW-1:0]      sx, sy;
  logic                  many;
  op_e                   op;

  always_comb begin
    node_x_d = node_x_q;
    node_y_d = node_y_q;
    if (cfg_we_i && cfg_idx_i == REG_NODE_X) begin
      node_x_d = cfg_wdata_i[COORD_BITS-1:0];
    end
    if (cfg_we_i && cfg_idx_i == REG_NODE_Y) begin
      node_y_d = cfg_wdata_i[COORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_x_q <= '0;
      node_y_q <= '0;
    end else begin
      node_x_q <= node_x_d;
      node_y_q <= node_y_d;
    end
  end

  assign tx         = s_axis_tdata_i[0*COORD_BITS +: COORD_BITS];
  assign ty         = s_axis_tdata_i[1*COORD_BITS +: COORD_BITS];
  assign vx         = s_axis_tdata_i[2*COORD_BITS +: COORD_BITS];
  assign vy         = s_axis_tdata_i[3*COORD_BITS +: COORD_BITS];
  assign reached_in = s_axis_tdata_i[4*COORD_BITS];

  // Rectangle between this node and the target
  always_comb begin
    if (tx < node_x_q) begin
      bx = tx;
      sx = {1'b0, node_x_q - tx} + SpanW'(1);
    end else begin
      bx = node_x_q;
      sx = {1'b0, tx - node_x_q} + SpanW'(1);
    end
    if (ty < node_y_q) begin
      by = ty;
      sy = {1'b0, node_y_q - ty} + SpanW'(1);
    end else begin
      by = node_y_q;
      sy = {1'b0, ty - node_y_q} + SpanW'(1);
    end
  end

  // More than two nodes in the rectangle
  assign many = !((sx == SpanW'(1) && sy <= SpanW'(2)) ||
                  (sy == SpanW'(1) && sx <= SpanW'(2)));

  // Injected headers default to the target; a successful draw overwrites it
  always_comb begin
    if (!s_axis_tuser_i) begin
      ex      = tx;
      ey      = ty;
      reached = (tx == node_x_q) && (ty == node_y_q);
      op      = many ? OP_DRAW : OP_DIRECT;
    end else begin
      ex      = vx;
      ey      = vy;
      reached = reached_in || ((vx == node_x_q) && (vy == node_y_q));
      op      = OP_TRANSIT;
    end
  end

  assign q_data_o        = {op, reached, by, bx, sy, sx, ey, ex, ty, tx};
  assign q_valid_o       = s_axis_tvalid_i;
  assign s_axis_tready_o = q_ready_i;
  assign node_x_o        = node_x_q;
  assign node_y_o        = node_y_q;

endmodule

// ===== design/rmrc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmrc_queue
// Short register FIFO between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module rmrc_queue #(
  parameter int WIDTH = 37,
  parameter int DEPTH = rmrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CntW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== design/rmrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmrc_back
// Draw the intermediate node with the LFSR, compute the XY output port and
// hold the result in the output register.
// ----------------------------------------------------------------------------
module rmrc_back #(
  parameter int COORD_BITS = rmrc_pkg::COORD_BITS_DEF,
  parameter int MAX_TRIES  = rmrc_pkg::MAX_TRIES_DEF,
  parameter int ENTRY_W    = 8 * COORD_BITS + 5,
  parameter int OUT_W      = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        seed_we_i,
  input  logic [rmrc_pkg::SEED_W-1:0] seed_i,
  input  logic [COORD_BITS-1:0]       node_x_i,
  input  logic [COORD_BITS-1:0]       node_y_i,
  input  logic                        q_valid_i,
  output logic                        q_ready_o,
  input  logic [ENTRY_W-1:0]          q_data_i,
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [OUT_W-1:0]            m_axis_tdata_o
);
  import rmrc_pkg::*;

  localparam int SpanW = COORD_BITS + 1;
  localparam int ProdW = SEED_W + SpanW;
  localparam int TryW  = $clog2(MAX_TRIES + 1);

  // Unpacked queue entry
  logic [1:0]            e_op_bits;
  op_e                   e_op;
  logic                  e_reached;
  logic [COORD_BITS-1:0] e_tx, e_ty, e_vx, e_vy, e_bx, e_by;
  logic [SpanW-1:0]      e_sx, e_sy;

  assign {e_op_bits, e_reached, e_by, e_bx, e_sy, e_sx, e_vy, e_vx, e_ty, e_tx} = q_data_i;
  assign e_op = op_e'(e_op_bits);

  state_e                state_q, state_d;
  logic [SEED_W-1:0]     lfsr_q, lfsr_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q, out_data_d;

  logic [COORD_BITS-1:0] tx_q, tx_d, ty_q, ty_d, vx_q, vx_d, vy_q, vy_d;
  logic [COORD_BITS-1:0] bx_q, bx_d, by_q, by_d, cx_q, cx_d, cy_q, cy_d;
  logic [SpanW-1:0]      sx_q, sx_d, sy_q, sy_d;
  logic                  reached_q, reached_d;
  logic [TryW-1:0]       tries_q, tries_d;

  logic [SEED_W-1:0]     lfsr_nx;
  logic [SpanW-1:0]      span_sel;
  logic [COORD_BITS-1:0] base_sel, draw;
  logic [ProdW-1:0]      prod;
  logic                  at_node, at_target;
  logic [COORD_BITS-1:0] dest_x, dest_y;
  port_e                 port;

  // Draw one coordinate: high part of the stepped LFSR times the span
  assign lfsr_nx  = lfsr_next(lfsr_q);
  assign span_sel = (state_q == ST_DRAW_X) ? sx_q : sy_q;
  assign base_sel = (state_q == ST_DRAW_X) ? bx_q : by_q;
  assign prod     = ProdW'(lfsr_nx) * ProdW'(span_sel);
  assign draw     = prod[SEED_W +: COORD_BITS] + base_sel;

  assign at_node   = (cx_q == node_x_i) && (cy_q == node_y_i);
  assign at_target = (cx_q == tx_q) && (cy_q == ty_q);

  // XY routing toward the via node, or the target once reached
  assign dest_x = reached_q ? tx_q : vx_q;
  assign dest_y = reached_q ? ty_q : vy_q;

  always_comb begin
    if (dest_x != node_x_i) begin
      port = (dest_x < node_x_i) ? PORT_WEST : PORT_EAST;
    end else if (dest_y != node_y_i) begin
      port = (dest_y < node_y_i) ? PORT_NORTH : PORT_SOUTH;
    end else begin
      port = PORT_LOCAL;
    end
  end

  assign q_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    lfsr_d      = lfsr_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_data_d  = out_data_q;
    tx_d = tx_q;  ty_d = ty_q;  vx_d = vx_q;  vy_d = vy_q;
    bx_d = bx_q;  by_d = by_q;  cx_d = cx_q;  cy_d = cy_q;
    sx_d = sx_q;  sy_d = sy_q;
    reached_d = reached_q;
    tries_d   = tries_q;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          tx_d = e_tx;  ty_d = e_ty;  vx_d = e_vx;  vy_d = e_vy;
          bx_d = e_bx;  by_d = e_by;  sx_d = e_sx;  sy_d = e_sy;
          reached_d = e_reached;
          tries_d   = '0;
          state_d   = (e_op == OP_DRAW) ? ST_DRAW_X : ST_ROUTE;
        end
      end
      ST_DRAW_X: begin
        lfsr_d  = lfsr_nx;
        cx_d    = draw;
        state_d = ST_DRAW_Y;
      end
      ST_DRAW_Y: begin
        lfsr_d  = lfsr_nx;
        cy_d    = draw;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (!at_node && !at_target) begin
          vx_d    = cx_q;
          vy_d    = cy_q;
          state_d = ST_ROUTE;
        end else if (tries_q == TryW'(MAX_TRIES - 1)) begin
          // out of retries: keep the target fallback loaded from the queue
          state_d = ST_ROUTE;
        end else begin
          tries_d = tries_q + TryW'(1);
          state_d = ST_DRAW_X;
        end
      end
      ST_ROUTE: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_data_d  = OUT_W'({reached_q, vy_q, vx_q, port});
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Seed write reloads the generator; zero would lock it
    if (seed_we_i) begin
      lfsr_d = (seed_i == '0) ? SEED_RESET : seed_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      lfsr_q      <= SEED_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      lfsr_q      <= lfsr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    tx_q <= tx_d;  ty_q <= ty_d;  vx_q <= vx_d;  vy_q <= vy_d;
    bx_q <= bx_d;  by_q <= by_d;  cx_q <= cx_d;  cy_q <= cy_d;
    sx_q <= sx_d;  sy_q <= sy_d;
    reached_q <= reached_d;
    tries_q   <= tries_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
